@@ src/bf16rd_pkg.sv @@
// Package for the BF16 row dot product block: shared types, constants and
// the IEEE single adder function. Depends on nothing else.
package bf16rd_pkg;

   localparam int BLOCK_LANES = 16;
   localparam int LANE_W      = 4;
   localparam int RSP_DEPTH   = 8;
   localparam int RSP_PTR_W   = 3;
   localparam int CSR_ADDR_W  = 4;
   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

   typedef enum logic [1:0] {
      REG_COLUMN_COUNT = 2'd0,
      REG_FIRST_ROW    = 2'd1,
      REG_END_ROW      = 2'd2,
      REG_UNUSED       = 2'd3
   } bf16rd_reg_type;

   typedef enum logic [1:0] {
      SPEC_NONE = 2'd0,
      SPEC_NAN  = 2'd1,
      SPEC_INF  = 2'd2,
      SPEC_ZERO = 2'd3
   } bf16rd_spec_type;

   typedef enum logic [2:0] {
      RED_IDLE   = 3'd0,
      RED_PAIRS  = 3'd1,
      RED_LANES  = 3'd2,
      RED_HALVES = 3'd3,
      RED_FINAL  = 3'd4
   } bf16rd_red_type;

   typedef struct packed {
      logic              full_col;
      logic [LANE_W-1:0] lane;
      logic              last_full;
      logic              emit;
      logic [15:0]       row;
      logic              done;
   } bf16rd_side_type;

   typedef struct packed {
      logic [31:0] row_sum_f32;
      logic [15:0] row_index;
      logic        range_done;
   } bf16rd_result_type;

   function automatic logic is_nan(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] x;
      logic [31:0] y;
      logic [7:0]  ex;
      logic [7:0]  ey;
      logic [23:0] mx;
      logic [23:0] my;
      logic [8:0]  d;
      logic [26:0] gy;
      logic [26:0] sy;
      logic [27:0] s;
      logic [9:0]  e;
      logic [9:0]  lz;
      logic [9:0]  sh;
      logic [26:0] n;
      logic [24:0] m;
      logic        inc;
      if (is_nan(a) || is_nan(b)) return CANON_NAN;
      if ((a[30:23] == 8'hFF) && (b[30:23] == 8'hFF)) begin
         return (a[31] != b[31]) ? CANON_NAN : a;
      end
      if (a[30:23] == 8'hFF) return a;
      if (b[30:23] == 8'hFF) return b;
      if (a[30:0] >= b[30:0]) begin
         x = a;
         y = b;
      end else begin
         x = b;
         y = a;
      end
      ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      mx = {(x[30:23] != 8'd0), x[22:0]};
      my = {(y[30:23] != 8'd0), y[22:0]};
      d  = {1'b0, ex} - {1'b0, ey};
      gy = {my, 3'b000};
      if (d >= 9'd27) begin
         sy    = 27'd0;
         sy[0] = |gy;
      end else begin
         sy    = gy >> d;
         sy[0] = sy[0] | (|(gy & ~({27{1'b1}} << d)));
      end
      if (x[31] == y[31]) begin
         s = {1'b0, mx, 3'b000} + {1'b0, sy};
      end else begin
         s = {1'b0, mx, 3'b000} - {1'b0, sy};
      end
      if (s == 28'd0) return {x[31] & y[31], 31'd0};
      e = {2'b00, ex};
      if (s[27]) begin
         n    = s[27:1];
         n[0] = s[1] | s[0];
         e    = e + 10'd1;
      end else begin
         lz = 10'd0;
         for (int i = 0; i < 27; i++) begin
            if (s[i]) lz = 10'(26 - i);
         end
         sh = (lz < (e - 10'd1)) ? lz : (e - 10'd1);
         n  = s[26:0] << sh;
         e  = e - sh;
      end
      inc = n[2] & (n[1] | n[0] | n[3]);
      m   = {1'b0, n[26:3]} + {24'd0, inc};
      if (m[24]) begin
         m = m >> 1;
         e = e + 10'd1;
      end
      if (e >= 10'd255) return {x[31], 8'hFF, 23'd0};
      return {x[31], (m[23] ? e[7:0] : 8'h00), m[22:0]};
   endfunction

endpackage

@@ src/bf16rd_if.sv @@
// Handshake interfaces for the input and result channels of the row dot
// product block. Depends on nothing else.
interface bf16rd_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] weight_bf16;
   logic [31:0] activation_f32;
   modport source (output valid, output weight_bf16, output activation_f32, input ready);
   modport sink (input valid, input weight_bf16, input activation_f32, output ready);
endinterface

interface bf16rd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] row_sum_f32;
   logic [15:0] row_index;
   logic        range_done;
   modport source (output valid, output row_sum_f32, output row_index, output range_done,
                   input ready);
   modport sink (input valid, input row_sum_f32, input row_index, input range_done,
                 output ready);
endinterface

@@ src/bf16rd_mul.sv @@
// Two-stage IEEE single multiplier with round to nearest even, carrying a
// sideband struct alongside. Depends on bf16rd_pkg.
module bf16rd_mul
   import bf16rd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [31:0]     a_f32,
   input  logic [31:0]     b_f32,
   input  bf16rd_side_type side_in,
   output logic            out_valid,
   output logic [31:0]     prod_f32,
   output bf16rd_side_type side_out
);

   logic            m1_valid_ff;
   logic [47:0]     m1_prod_ff;
   logic [47:0]     m1_prod_in;
   logic [9:0]      m1_exp_ff;
   logic [9:0]      m1_exp_in;
   logic            m1_sign_ff;
   bf16rd_spec_type m1_spec_ff;
   bf16rd_spec_type m1_spec_in;
   bf16rd_side_type m1_side_ff;

   logic            p_valid_ff;
   logic [31:0]     p_prod_ff;
   logic [31:0]     p_prod_in;
   bf16rd_side_type p_side_ff;

   always_comb begin
      logic [7:0]  ea;
      logic [7:0]  eb;
      logic [23:0] ma;
      logic [23:0] mb;
      logic        a_inf;
      logic        b_inf;
      logic        a_zero;
      logic        b_zero;
      ea     = (a_f32[30:23] == 8'd0) ? 8'd1 : a_f32[30:23];
      eb     = (b_f32[30:23] == 8'd0) ? 8'd1 : b_f32[30:23];
      ma     = {(a_f32[30:23] != 8'd0), a_f32[22:0]};
      mb     = {(b_f32[30:23] != 8'd0), b_f32[22:0]};
      a_inf  = (a_f32[30:23] == 8'hFF) && (a_f32[22:0] == 23'd0);
      b_inf  = (b_f32[30:23] == 8'hFF) && (b_f32[22:0] == 23'd0);
      a_zero = (a_f32[30:0] == 31'd0);
      b_zero = (b_f32[30:0] == 31'd0);
      if (is_nan(a_f32) || is_nan(b_f32) || (a_inf && b_zero) || (b_inf && a_zero)) begin
         m1_spec_in = SPEC_NAN;
      end else if (a_inf || b_inf) begin
         m1_spec_in = SPEC_INF;
      end else if (a_zero || b_zero) begin
         m1_spec_in = SPEC_ZERO;
      end else begin
         m1_spec_in = SPEC_NONE;
      end
      m1_prod_in = {24'd0, ma} * {24'd0, mb};
      m1_exp_in  = {2'b00, ea} + {2'b00, eb} - 10'd127;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= in_valid;
      end
      m1_prod_ff <= m1_prod_in;
      m1_exp_ff  <= m1_exp_in;
      m1_sign_ff <= a_f32[31] ^ b_f32[31];
      m1_spec_ff <= m1_spec_in;
      m1_side_ff <= side_in;
   end

   always_comb begin
      logic [5:0]        lz;
      logic signed [9:0] e;
      logic [9:0]        rsh;
      logic [47:0]       n;
      logic              sticky;
      logic              inc;
      logic [24:0]       m;
      lz = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (m1_prod_ff[i]) lz = 6'(47 - i);
      end
      sticky = 1'b0;
      rsh    = 10'd0;
      if (!m1_exp_ff[9] && ({4'd0, lz} <= m1_exp_ff)) begin
         n = m1_prod_ff << lz;
         e = $signed(m1_exp_ff) + 10'sd1 - $signed({4'd0, lz});
      end else if (!m1_exp_ff[9]) begin
         n = m1_prod_ff << m1_exp_ff[5:0];
         e = 10'sd1;
      end else begin
         rsh = 10'd0 - m1_exp_ff;
         e   = 10'sd1;
         if (rsh >= 10'd48) begin
            n      = 48'd0;
            sticky = |m1_prod_ff;
         end else begin
            n      = m1_prod_ff >> rsh;
            sticky = |(m1_prod_ff & ~({48{1'b1}} << rsh));
         end
      end
      inc = n[23] & ((|n[22:0]) | sticky | n[24]);
      m   = {1'b0, n[47:24]} + {24'd0, inc};
      if (m[24]) begin
         m = m >> 1;
         e = e + 10'sd1;
      end
      case (m1_spec_ff)
         SPEC_NAN:  p_prod_in = CANON_NAN;
         SPEC_INF:  p_prod_in = {m1_sign_ff, 8'hFF, 23'd0};
         SPEC_ZERO: p_prod_in = {m1_sign_ff, 31'd0};
         default: begin
            if (e >= 10'sd255) begin
               p_prod_in = {m1_sign_ff, 8'hFF, 23'd0};
            end else begin
               p_prod_in = {m1_sign_ff, (m[23] ? e[7:0] : 8'h00), m[22:0]};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= m1_valid_ff;
      end
      p_prod_ff <= p_prod_in;
      p_side_ff <= m1_side_ff;
   end

   assign out_valid = p_valid_ff;
   assign prod_f32  = p_prod_ff;
   assign side_out  = p_side_ff;

endmodule

@@ src/bf16_row_dot_product_top.sv @@
// Top level of the BF16 x FP32 row dot product block: APB register port,
// column bookkeeping, accumulators, reduction and result queue.
// Depends on bf16rd_pkg, bf16rd_if and bf16rd_mul.
//
// Usage: each item on req_chan carries one bfloat16 weight and one single
// precision activation; after column_count items one item leaves on rsp_chan
// with the row sum, its row index and a flag for the last row of the range.
// An item is accepted whenever valid and ready are both high.
// Throughput is one item per cycle while ready is high. The result of a row
// that ends in its tail columns passes through the multiplier stages into
// the queue. After the last item of the full blocks of sixteen columns,
// ready stays low while the sixteen partial sums are reduced in four levels
// of adders; a row that ends there is written into the queue by the last level.
// Results wait in an eight-entry queue; input is taken while results wait and
// is held off when eight results are outstanding or during the reduction.
// Reset restores 16 columns, first row 0, end row 1, clears all sums and
// empties the queue. Writing a defined register abandons the row in progress.
module bf16_row_dot_product_top
   import bf16rd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bf16rd_req_if.sink            req_chan,
   bf16rd_rsp_if.source          rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [15:0] column_count_ff;
   logic [15:0] first_row_ff;
   logic [16:0] end_row_ff;
   logic [15:0] pos_ff;
   logic [15:0] row_ff;
   logic        stall_ff;
   logic        stall_in;
   logic [RSP_PTR_W:0] pending_ff;
   logic [RSP_PTR_W:0] pending_in;

   logic           cfg_we;
   logic           cfg_hit;
   bf16rd_reg_type cfg_reg;
   logic           req_accept;
   logic [16:0]    cols;
   logic [16:0]    full_end;
   logic [15:0]    pos_next;
   bf16rd_side_type side_now;

   logic            acc_valid;
   logic [31:0]     prod;
   bf16rd_side_type acc_side;

   logic [31:0] psum_ff [BLOCK_LANES];
   logic [31:0] tail_ff;
   logic [31:0] lane_sum;
   logic [31:0] tail_sum;
   logic [31:0] red_a [8];
   logic [31:0] red_b [8];
   logic [31:0] red_res [8];
   bf16rd_red_type red_ff;
   bf16rd_red_type red_in;
   logic        red_emit_ff;
   logic [15:0] red_row_ff;
   logic        red_done_ff;

   bf16rd_result_type fifo_mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_PTR_W:0]   count_ff;
   logic                 push;
   logic                 pop;
   bf16rd_result_type    push_data;
   bf16rd_result_type    head;

   // Register port.
   assign csr_pready = 1'b1;
   assign cfg_reg    = bf16rd_reg_type'(csr_paddr[3:2]);
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite;
   assign cfg_hit    = cfg_we && (cfg_reg != REG_UNUSED);

   always_comb begin
      unique case (cfg_reg)
         REG_COLUMN_COUNT: csr_prdata = {16'd0, column_count_ff};
         REG_FIRST_ROW:    csr_prdata = {16'd0, first_row_ff};
         REG_END_ROW:      csr_prdata = {15'd0, end_row_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= 16'd16;
         first_row_ff    <= 16'd0;
         end_row_ff      <= 17'd1;
      end else if (cfg_we) begin
         unique case (cfg_reg)
            REG_COLUMN_COUNT: column_count_ff <= csr_pwdata[15:0];
            REG_FIRST_ROW:    first_row_ff    <= csr_pwdata[15:0];
            REG_END_ROW:      end_row_ff      <= csr_pwdata[16:0];
            default:          ;
         endcase
      end
   end

   // Column and row bookkeeping at acceptance.
   assign req_accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !stall_ff && (pending_ff < (RSP_PTR_W+1)'(RSP_DEPTH));
   assign cols     = (column_count_ff == 16'd0) ? 17'h10000 : {1'b0, column_count_ff};
   assign full_end = {cols[16:LANE_W], {LANE_W{1'b0}}};
   assign pos_next = pos_ff + 16'd1;

   always_comb begin
      side_now.full_col  = ({1'b0, pos_ff} < full_end);
      side_now.lane      = pos_ff[LANE_W-1:0];
      side_now.last_full = (({1'b0, pos_ff} + 17'd1) == full_end);
      side_now.emit      = (pos_next == column_count_ff);
      side_now.row       = row_ff;
      side_now.done      = (({1'b0, row_ff} + 17'd1) >= end_row_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 16'd0;
         row_ff <= 16'd0;
      end else if (cfg_hit) begin
         pos_ff <= 16'd0;
         row_ff <= (cfg_reg == REG_FIRST_ROW) ? csr_pwdata[15:0] : first_row_ff;
      end else if (req_accept) begin
         if (side_now.emit) begin
            pos_ff <= 16'd0;
            row_ff <= side_now.done ? first_row_ff : (row_ff + 16'd1);
         end else begin
            pos_ff <= pos_next;
         end
      end
   end

   assign stall_in = (req_accept && side_now.last_full) ? 1'b1 :
                     ((red_ff == RED_FINAL) ? 1'b0 : stall_ff);
   assign pending_in = pending_ff + (RSP_PTR_W+1)'(req_accept && side_now.emit)
                       - (RSP_PTR_W+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         stall_ff   <= 1'b0;
         pending_ff <= '0;
      end else begin
         stall_ff   <= stall_in;
         pending_ff <= pending_in;
      end
   end

   bf16rd_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .a_f32     ({req_chan.weight_bf16, 16'd0}),
      .b_f32     (req_chan.activation_f32),
      .side_in   (side_now),
      .out_valid (acc_valid),
      .prod_f32  (prod),
      .side_out  (acc_side)
   );

   // Accumulation and reduction.
   assign lane_sum = fp_add(psum_ff[acc_side.lane], prod);
   assign tail_sum = fp_add(tail_ff, prod);

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         red_a[k] = 32'd0;
         red_b[k] = 32'd0;
      end
      unique case (red_ff)
         RED_PAIRS: begin
            for (int k = 0; k < 4; k++) begin
               red_a[k]     = psum_ff[k];
               red_b[k]     = psum_ff[k + 4];
               red_a[k + 4] = psum_ff[k + 8];
               red_b[k + 4] = psum_ff[k + 12];
            end
         end
         RED_LANES: begin
            for (int k = 0; k < 4; k++) begin
               red_a[k] = psum_ff[k];
               red_b[k] = psum_ff[k + 8];
            end
         end
         RED_HALVES: begin
            red_a[0] = psum_ff[0];
            red_b[0] = psum_ff[2];
            red_a[1] = psum_ff[1];
            red_b[1] = psum_ff[3];
         end
         RED_FINAL: begin
            red_a[0] = psum_ff[0];
            red_b[0] = psum_ff[1];
         end
         default: ;
      endcase
      for (int k = 0; k < 8; k++) begin
         red_res[k] = fp_add(red_a[k], red_b[k]);
      end
   end

   always_comb begin
      unique case (red_ff)
         RED_IDLE:   red_in = (acc_valid && acc_side.last_full) ? RED_PAIRS : RED_IDLE;
         RED_PAIRS:  red_in = RED_LANES;
         RED_LANES:  red_in = RED_HALVES;
         RED_HALVES: red_in = RED_FINAL;
         default:    red_in = RED_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff <= RED_IDLE;
      end else begin
         red_ff <= red_in;
      end
      if (acc_valid && acc_side.last_full) begin
         red_emit_ff <= acc_side.emit;
         red_row_ff  <= acc_side.row;
         red_done_ff <= acc_side.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         for (int k = 0; k < BLOCK_LANES; k++) psum_ff[k] <= 32'd0;
         tail_ff <= 32'd0;
      end else if (acc_valid) begin
         if (acc_side.emit && !acc_side.last_full) begin
            for (int k = 0; k < BLOCK_LANES; k++) psum_ff[k] <= 32'd0;
            tail_ff <= 32'd0;
         end else if (acc_side.full_col) begin
            psum_ff[acc_side.lane] <= lane_sum;
         end else begin
            tail_ff <= tail_sum;
         end
      end else begin
         case (red_ff)
            RED_PAIRS: begin
               for (int k = 0; k < 4; k++) begin
                  psum_ff[k]     <= red_res[k];
                  psum_ff[k + 8] <= red_res[k + 4];
               end
            end
            RED_LANES: begin
               for (int k = 0; k < 4; k++) psum_ff[k] <= red_res[k];
            end
            RED_HALVES: begin
               psum_ff[0] <= red_res[0];
               psum_ff[1] <= red_res[1];
            end
            RED_FINAL: begin
               if (red_emit_ff) begin
                  for (int k = 0; k < BLOCK_LANES; k++) psum_ff[k] <= 32'd0;
                  tail_ff <= 32'd0;
               end else begin
                  tail_ff <= red_res[0];
               end
            end
            default: ;
         endcase
      end
   end

   // Result queue.
   always_comb begin
      if (red_ff == RED_FINAL) begin
         push                  = red_emit_ff;
         push_data.row_sum_f32 = red_res[0];
         push_data.row_index   = red_row_ff;
         push_data.range_done  = red_done_ff;
      end else begin
         push                  = acc_valid && acc_side.emit && !acc_side.last_full;
         push_data.row_sum_f32 = tail_sum;
         push_data.row_index   = acc_side.row;
         push_data.range_done  = acc_side.done;
      end
   end

   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign head = fifo_mem[rd_ptr_ff];
   assign rsp_chan.valid       = (count_ff != '0);
   assign rsp_chan.row_sum_f32 = head.row_sum_f32;
   assign rsp_chan.row_index   = head.row_index;
   assign rsp_chan.range_done  = head.range_done;

   always_ff @(posedge clock) begin
      if (push) fifo_mem[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (RSP_PTR_W+1)'(push) - (RSP_PTR_W+1)'(pop);
      end
   end

`ifndef SYNTHESIS
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= (RSP_PTR_W+1)'(RSP_DEPTH))
      else $error("more results outstanding than the queue holds");

   a_queue_covered: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pending_ff)
      else $error("queue holds results that were never counted");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < (RSP_PTR_W+1)'(RSP_DEPTH)))
      else $error("result written into a full queue");

   a_reduce_alone: assert property (@(posedge clock) disable iff (reset)
      (red_ff != RED_IDLE) |-> !acc_valid)
      else $error("item reached the accumulators during the reduction");
`endif

endmodule

@@ sim/bf16_row_dot_product_top_tb.sv @@
// Self-checking testbench for bf16_row_dot_product_top: drives weight and activation
// items and register writes, and checks every result bit-exactly against a single
// precision model or a pinned sum. Depends on bf16rd_pkg, bf16rd_if and the block's RTL.
`timescale 1ns / 1ps

module bf16_row_dot_product_top_tb;
   import bf16rd_pkg::*;

   typedef struct {
      logic [15:0] weight;
      logic [31:0] act;
      bit          pinned;
      logic [31:0] sum;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   bf16rd_req_if req_chan ();
   bf16rd_rsp_if rsp_chan ();

   bf16rd_result_type expected_rows[$];
   bit                pin_flags[$];
   logic [31:0]       pin_sums[$];
   int                error_count = 0;
   int                quiet_cycles = 0;
   bit                stall_en = 1'b0;

   logic [15:0] cfg_columns;
   logic [15:0] cfg_first;
   logic [16:0] cfg_end;
   logic [31:0] lane_sums[BLOCK_LANES];
   logic [31:0] run_sum;
   logic [15:0] col_pos;
   logic [15:0] row_now;

   bf16_row_dot_product_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   initial begin
      req_chan.valid          = 1'b0;
      req_chan.weight_bf16    = '0;
      req_chan.activation_f32 = '0;
      rsp_chan.ready          = 1'b0;
   end

   function automatic bit f32_is_nan(input logic [31:0] v);
      return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
   endfunction

   // Rounds mag * 2**scale to single precision, nearest even; mag must be non-zero.
   function automatic logic [31:0] f32_round(input logic sgn, input int scale,
                                             input logic [63:0] mag);
      int           top;
      int           lsb;
      int           sh;
      int           bexp;
      logic [127:0] wide;
      logic [63:0]  keep;
      logic         guard;
      logic         sticky;
      top = 0;
      for (int i = 0; i < 64; i++) if (mag[i]) top = i;
      lsb = top + scale - 23;
      if (lsb < -149) lsb = -149;
      sh = lsb - scale;
      if (sh > 64) begin
         keep = '0; guard = 1'b0; sticky = 1'b1;
      end else if (sh > 0) begin
         wide = {mag, 64'd0} >> sh;
         keep = wide[127:64]; guard = wide[63]; sticky = |wide[62:0];
      end else begin
         keep = mag << (-sh); guard = 1'b0; sticky = 1'b0;
      end
      if (guard && (sticky || keep[0])) keep = keep + 64'd1;
      if (keep[24]) begin
         keep = keep >> 1;
         lsb = lsb + 1;
      end
      if (!keep[23]) return {sgn, 8'h00, keep[22:0]};
      bexp = lsb + 150;
      if (bexp >= 255) return {sgn, 8'hFF, 23'd0};
      return {sgn, bexp[7:0], keep[22:0]};
   endfunction

   function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
      logic        sgn;
      int          ea;
      int          eb;
      logic [63:0] ma;
      logic [63:0] mb;
      sgn = a[31] ^ b[31];
      if (f32_is_nan(a) || f32_is_nan(b)) return CANON_NAN;
      if (a[30:23] == 8'hFF) return (b[30:0] == 31'd0) ? CANON_NAN : {sgn, 8'hFF, 23'd0};
      if (b[30:23] == 8'hFF) return (a[30:0] == 31'd0) ? CANON_NAN : {sgn, 8'hFF, 23'd0};
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {sgn, 31'd0};
      ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
      eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
      ma = {40'd0, a[30:23] != 8'd0, a[22:0]};
      mb = {40'd0, b[30:23] != 8'd0, b[22:0]};
      return f32_round(sgn, ea + eb - 300, ma * mb);
   endfunction

   function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] big;
      logic [31:0] sml;
      int          eb;
      int          es;
      int          scale;
      logic [63:0] mb;
      logic [63:0] ms;
      logic [63:0] mag;
      if (f32_is_nan(a) || f32_is_nan(b)) return CANON_NAN;
      if (a[30:23] == 8'hFF && b[30:23] == 8'hFF) return (a[31] != b[31]) ? CANON_NAN : a;
      if (a[30:23] == 8'hFF) return a;
      if (b[30:23] == 8'hFF) return b;
      if (a[30:0] >= b[30:0]) begin
         big = a; sml = b;
      end else begin
         big = b; sml = a;
      end
      eb = (big[30:23] == 8'd0) ? 1 : int'(big[30:23]);
      es = (sml[30:23] == 8'd0) ? 1 : int'(sml[30:23]);
      mb = {40'd0, big[30:23] != 8'd0, big[22:0]};
      ms = {40'd0, sml[30:23] != 8'd0, sml[22:0]};
      if (eb - es > 40) begin
         mb = mb << 40;
         ms = (ms != 64'd0) ? 64'd1 : 64'd0;
         scale = eb - 190;
      end else begin
         mb = mb << (eb - es);
         scale = es - 150;
      end
      mag = (big[31] == sml[31]) ? mb + ms : mb - ms;
      if (mag == 64'd0) return {big[31] & sml[31], 31'd0};
      return f32_round(big[31], scale, mag);
   endfunction

   function automatic void clear_row_sums();
      foreach (lane_sums[i]) lane_sums[i] = 32'd0;
      run_sum = 32'd0;
      col_pos = 16'd0;
   endfunction

   function automatic void model_write(input bf16rd_reg_type idx, input logic [31:0] val);
      case (idx)
         REG_COLUMN_COUNT: cfg_columns = val[15:0];
         REG_FIRST_ROW:    cfg_first = val[15:0];
         REG_END_ROW:      cfg_end = val[16:0];
         default:          return;
      endcase
      clear_row_sums();
      row_now = cfg_first;
   endfunction

   function automatic logic [31:0] fold_lanes();
      logic [31:0] quad[4];
      for (int j = 0; j < 4; j++)
         quad[j] = f32_add(f32_add(lane_sums[j], lane_sums[4 + j]),
                           f32_add(lane_sums[8 + j], lane_sums[12 + j]));
      return f32_add(f32_add(quad[0], quad[2]), f32_add(quad[1], quad[3]));
   endfunction

   // Accumulates one column; returns 1 with the row sum when the row is complete.
   function automatic bit accumulate_column(input logic [15:0] weight, input logic [31:0] act,
                                            output bf16rd_result_type row_out);
      logic [16:0] cols;
      logic [16:0] full_end;
      logic [31:0] prod;
      logic [15:0] nxt;
      bit          last;
      cols = (cfg_columns == 16'd0) ? 17'h10000 : {1'b0, cfg_columns};
      full_end = cols & ~17'(BLOCK_LANES - 1);
      prod = f32_mul({weight, 16'd0}, act);
      nxt = col_pos + 16'd1;
      if ({1'b0, col_pos} < full_end) begin
         lane_sums[col_pos[3:0]] = f32_add(lane_sums[col_pos[3:0]], prod);
         if ({1'b0, col_pos} + 17'd1 == full_end) run_sum = fold_lanes();
      end else begin
         run_sum = f32_add(run_sum, prod);
      end
      if (nxt != cfg_columns) begin
         col_pos = nxt;
         return 1'b0;
      end
      last = ({1'b0, row_now} + 17'd1) >= cfg_end;
      row_out.row_sum_f32 = run_sum;
      row_out.row_index = row_now;
      row_out.range_done = last;
      clear_row_sums();
      row_now = last ? cfg_first : row_now + 16'd1;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      bf16rd_result_type row_out;
      bf16rd_result_type want;
      bit                pinned;
      logic [31:0]       pin_sum;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_rows.size() == 0) begin
               report_mismatch("unexpected item", rsp_chan.row_sum_f32, 32'd0);
            end else begin
               want = expected_rows.pop_front();
               if (rsp_chan.row_sum_f32 !== want.row_sum_f32)
                  report_mismatch("row_sum_f32", rsp_chan.row_sum_f32, want.row_sum_f32);
               if (rsp_chan.row_index !== want.row_index)
                  report_mismatch("row_index", 32'(rsp_chan.row_index),
                                  32'(want.row_index));
               if (rsp_chan.range_done !== want.range_done)
                  report_mismatch("range_done", 32'(rsp_chan.range_done),
                                  32'(want.range_done));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            pinned = 1'b0;
            pin_sum = '0;
            if (pin_flags.size() != 0) begin
               pinned = pin_flags.pop_front();
               pin_sum = pin_sums.pop_front();
            end
            if (accumulate_column(req_chan.weight_bf16, req_chan.activation_f32, row_out)) begin
               if (pinned) row_out.row_sum_f32 = pin_sum;
               expected_rows.push_back(row_out);
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= !(stall_en && $urandom_range(99) < 6);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 5000) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [15:0] weight, input logic [31:0] act);
      bit taken;
      while (stall_en && $urandom_range(99) < 6) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.weight_bf16    <= weight;
      req_chan.activation_f32 <= act;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_chan.ready;
         @(negedge clock);
      end
   endtask

   task automatic csr_write(input bf16rd_reg_type idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      model_write(idx, val);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (expected_rows.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_range(input logic [31:0] cols, input logic [31:0] first,
                            input logic [31:0] last);
      drain_results();
      csr_write(REG_COLUMN_COUNT, cols);
      csr_write(REG_FIRST_ROW, first);
      csr_write(REG_END_ROW, last);
   endtask

   function automatic logic [31:0] pick_f32();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(19))
         0:       v = {v[31], 31'd0};
         1:       v = {v[31], 8'hFF, 23'd0};
         2:       v = {v[31], 8'hFF, v[22:1], 1'b1};
         3:       v = {v[31], 8'h00, v[22:0]};
         4:       v = {v[31], 8'hFE, v[22:0]};
         5, 6:    ;
         default: v = {v[31], 8'(100 + $urandom_range(55)), v[22:0]};
      endcase
      return v;
   endfunction

   function automatic logic [31:0] pick_tame();
      logic [31:0] v;
      v = $urandom;
      return {v[31], 8'(115 + $urandom_range(25)), v[22:0]};
   endfunction

   stim_row_type directed[] = '{
      '{16'h3F80, 32'h3F80_0000, 1'b1, 32'h3F80_0000},
      '{16'h4000, 32'hC040_0000, 1'b1, 32'hC0C0_0000},
      '{16'h7FC1, 32'h3F80_0000, 1'b1, 32'h7FC0_0000},
      '{16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'h7FC0_0000},
      '{16'h7F80, 32'h0000_0000, 1'b1, 32'h7FC0_0000},
      '{16'hFF80, 32'h3F80_0000, 1'b1, 32'hFF80_0000},
      '{16'h7F7F, 32'h7F7F_FFFF, 1'b1, 32'h7F80_0000},
      '{16'h8000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{16'h0000, 32'h8000_0000, 1'b1, 32'h0000_0000},
      '{16'h0001, 32'h0000_0001, 1'b1, 32'h0000_0000},
      '{16'h0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{16'h0080, 32'h3F00_0000, 1'b0, 32'h0},
      '{16'h0080, 32'h3EFF_FFFF, 1'b0, 32'h0},
      '{16'h3F80, 32'h7F7F_FFFF, 1'b0, 32'h0},
      '{16'h3F81, 32'h3F7F_FFFF, 1'b0, 32'h0},
      '{16'h007F, 32'h4000_0001, 1'b0, 32'h0},
      '{16'hAAAA, 32'h5555_5555, 1'b0, 32'h0},
      '{16'h5555, 32'hAAAA_AAAA, 1'b0, 32'h0}
   };

   initial begin
      int n_items;
      cfg_columns = 16'd16;
      cfg_first = 16'd0;
      cfg_end = 17'd1;
      row_now = 16'd0;
      clear_row_sums();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default registers after reset: rows of sixteen columns, range of one row.
      for (int i = 0; i < 48; i++) send_item(16'(pick_f32() >> 16), pick_f32());

      set_range(32'd1, 32'd0, 32'd1);
      foreach (directed[i]) begin
         pin_flags.push_back(directed[i].pinned);
         pin_sums.push_back(directed[i].sum);
         send_item(directed[i].weight, directed[i].act);
      end

      drain_results();
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);
      for (int i = 0; i < 4; i++) send_item(16'(pick_f32() >> 16), pick_f32());

      for (int ph = 0; ph < 14; ph++) begin
         logic [31:0] cols;
         logic [31:0] first;
         logic [31:0] last;
         case (ph % 7)
            0:       cols = 16;
            1:       cols = 17;
            2:       cols = 15;
            3:       cols = 32 + $urandom_range(2);
            default: cols = 1 + $urandom_range(40);
         endcase
         first = $urandom_range(20);
         last = first + $urandom_range(4);
         if (ph == 3) begin
            first = 16'hFFFE;
            last = 17'h10000;
         end
         if (ph == 5) begin
            first = 16'hFFFF;
            last = 32'd3;
         end
         if (ph == 9) last = 32'd1;
         stall_en = (ph % 4) != 1;
         set_range(cols, first, last);
         n_items = 110 + $urandom_range(20);
         for (int i = 0; i < n_items; i++) send_item(16'(pick_f32() >> 16), pick_f32());
      end

      // Longest rows: 65536 columns (register value zero) and 65535 columns, each
      // started but not finished; the first is abandoned by the next register write.
      stall_en = 1'b1;
      set_range(32'd0, 32'd0, 32'h10000);
      for (int i = 0; i < 40; i++) send_item(16'(pick_tame() >> 16), pick_tame());
      set_range(32'hFFFF, 32'hFFFF, 32'h10000);
      for (int i = 0; i < 40; i++) send_item(16'(pick_tame() >> 16), pick_tame());

      drain_results();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
